// File: design/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants for the key counter table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int KEY_W       = 31;
  localparam int COUNT_W     = 31;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_GET = 2'd1,
    OP_SET = 2'd2,
    OP_BAD = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;    // capture request, restart scan
    logic scan;    // step the key search
    logic commit;  // write back and load the result register
  } kct_cmd_t;

  typedef struct packed {
    logic invalid;   // request rejected before search
    logic scan_hit;  // key found this cycle
    logic scan_end;  // all filled entries searched, no match
    logic out_free;  // result register can take a new item
  } kct_stat_t;

endpackage

// File: design/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Request sequencer: accept, check, search, write back.
// ----------------------------------------------------------------------------
module kct_ctrl
  import kct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  kct_stat_t stat,
  output kct_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.invalid ? S_UPDATE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit || stat.scan_end) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/kct_dp.sv
// ----------------------------------------------------------------------------
// kct_dp
// Request registers, entry memory, search counter, fill count, result register.
// ----------------------------------------------------------------------------
module kct_dp
  import kct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
)
(
  input  logic                clk,
  input  logic                rst,
  input  kct_cmd_t            cmd,
  output kct_stat_t           stat,
  input  logic [OP_W-1:0]     operation,
  input  logic signed [31:0]  key,
  input  logic signed [31:0]  new_count,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [COUNT_W-1:0]  count_out,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int DW = KEY_W + COUNT_W;

  logic [DW-1:0] mem [ENTRIES];

  op_t               op_q;
  logic [31:0]       key_q;
  logic [31:0]       cnt_q;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     idx;
  logic              rd_live;
  logic [AW-1:0]     rd_idx;
  logic [DW-1:0]     rd_data;
  logic              hit;
  logic [AW-1:0]     hit_idx;
  logic [COUNT_W-1:0] hit_count;

  logic               more;
  logic               rd_en;
  logic               full;
  logic               we;
  logic               fill_inc;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] newc;
  logic [COUNT_W-1:0] res_count;
  status_t            res_status;

  assign more  = idx < fill;
  assign rd_en = cmd.scan && more;
  assign full  = fill == FW'(ENTRIES);

  assign stat.invalid  = (op_q == OP_BAD) || key_q[31] || (op_q == OP_SET && cnt_q[31]);
  assign stat.scan_hit = rd_live && (rd_data[DW-1 -: KEY_W] == key_q[KEY_W-1:0]);
  assign stat.scan_end = !rd_live && !more;
  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(operation);
      key_q <= key;
      cnt_q <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && we) begin
      mem[waddr] <= {key_q[KEY_W-1:0], newc};
    end
    if (rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
      rd_idx  <= idx[AW-1:0];
    end
    if (cmd.scan && stat.scan_hit) begin
      hit_idx   <= rd_idx;
      hit_count <= rd_data[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_live <= 1'b0;
      hit     <= 1'b0;
      fill    <= '0;
    end else begin
      if (cmd.load) begin
        idx     <= '0;
        rd_live <= 1'b0;
        hit     <= 1'b0;
      end else if (cmd.scan) begin
        rd_live <= more;
        if (more) begin
          idx <= idx + FW'(1);
        end
        if (stat.scan_hit) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit && fill_inc) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_comb begin
    res_count  = '0;
    res_status = ST_OK;
    we         = 1'b0;
    fill_inc   = 1'b0;
    waddr      = hit_idx;
    newc       = (op_q == OP_ADD) ? COUNT_ONE : cnt_q[COUNT_W-1:0];
    if (stat.invalid) begin
      res_status = ST_INVALID;
    end else if (op_q == OP_GET) begin
      res_count = hit ? hit_count : '0;
    end else if (hit) begin
      if (op_q == OP_ADD) begin
        newc = (hit_count == COUNT_MAX) ? COUNT_MAX : hit_count + COUNT_ONE;
      end
      we        = 1'b1;
      res_count = newc;
    end else if (full) begin
      res_status = ST_FULL;
    end else begin
      we        = 1'b1;
      fill_inc  = 1'b1;
      waddr     = fill[AW-1:0];
      res_count = newc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      count_out <= res_count;
      status    <= res_status;
    end
  end

endmodule

// File: design/key_counter_table.sv
// ----------------------------------------------------------------------------
// key_counter_table
// Bounded key/count table with add, get and set requests.
// ----------------------------------------------------------------------------
// Request channel: req_valid/req_stall with operation, key and new_count.
// Response channel: rsp_valid/rsp_stall with count_out and status; exactly
// one response item per request item, in order.
// A request is taken only while the block is idle; it then passes a check
// state and a key search over the filled entries, one registered memory
// read per cycle, then a write-back state. A rejected request skips the
// search. No new request is taken until the current one is written back.
// The next request is accepted on the cycle after the response is loaded,
// even while that response is still stalled in the output register.
// If the receiver stalls, the response holds and a finished write-back
// waits until the output register frees up.
// Reset empties the table (fill count to zero); entries are
// filled in order and never removed, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_counter_table
  import kct_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic signed [31:0]  key,
  input  logic signed [31:0]  new_count,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [COUNT_W-1:0]  count_out,
  output logic [STATUS_W-1:0] status
);

  kct_cmd_t  cmd;
  kct_stat_t stat;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  kct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .key       (key),
    .new_count (new_count),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .count_out (count_out),
    .status    (status)
  );

endmodule

// File: design/kct_checker.sv
// ----------------------------------------------------------------------------
// kct_checker
// Port-level checks for the key counter table, bound to the top level.
// ----------------------------------------------------------------------------
module kct_checker
  import kct_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [COUNT_W-1:0]  count_out,
  input logic [STATUS_W-1:0] status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(count_out) && $stable(status))
    else $error("stalled response item changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != ST_UNUSED)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_INVALID || status == ST_FULL) |-> count_out == '0)
    else $error("failed request returned a nonzero count");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(rsp_valid))
    else $error("response item one cycle after request");

endmodule

bind key_counter_table kct_checker u_kct_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .count_out (count_out),
  .status    (status)
);
